FILE: hdl/smpq_pkg.sv
package smpq_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;
  localparam int COUNT_OUT_W  = 5;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_POPPED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } smpq_ctl_t;

endpackage

FILE: hdl/smpq_cell.sv
module smpq_cell
  import smpq_pkg::*;
(
  input  logic      clk,
  input  smpq_ctl_t ctl,
  input  data_t     in_value,
  input  logic      is_valid,
  input  logic      left_keep,
  input  data_t     left_value,
  input  data_t     right_value,
  output logic      keep,
  output data_t     entry
);

  data_t entry_r;
  data_t entry_nxt;

  // keep: this entry stays put on insert (entry valid and stored value <= new one)
  assign keep  = is_valid && (entry_r <= in_value);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (!keep) begin
        entry_nxt = left_keep ? in_value : left_value;
      end
    end else if (ctl.pop) begin
      entry_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: hdl/sorted_min_priority_queue.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_req_type, in_value
// out      output     out_valid / out_ready  out_status, out_popped_value, out_entry_count
//
// One item per cycle: every cell compares against the new value in parallel
// and shifts in the same cycle; the result is registered for the cycle after accept.
// in_ready drops only while a result is held and out_ready is low.
// Reset clears the entry count and the result valid; cell contents need none.
module sorted_min_priority_queue
  import smpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_req_type,
  input  logic signed [31:0]     in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic signed [31:0]     out_popped_value,
  output logic [COUNT_OUT_W-1:0] out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_valid_r;
  logic [1:0]             status_r;
  data_t                  popped_r;
  logic [COUNT_OUT_W-1:0] count_out_r;

  logic      acc;
  logic      full;
  logic      empty;
  smpq_ctl_t ctl;
  logic [1:0] status_nxt;
  data_t      popped_nxt;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  logic  keep  [CAPACITY];
  data_t entry [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);

  assign ctl.ins = acc && (in_req_type == REQ_INSERT) && !full;
  assign ctl.pop = acc && (in_req_type == REQ_POP) && !empty;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      smpq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .in_value    (in_value),
        .is_valid    (count_r > CW'(g)),
        .left_keep   ((g == 0) ? 1'b1 : keep[(g == 0) ? 0 : g-1]),
        .left_value  (entry[(g == 0) ? 0 : g-1]),
        .right_value (entry[(g == CAPACITY-1) ? g : g+1]),
        .keep        (keep[g]),
        .entry       (entry[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    if (in_req_type == REQ_INSERT) begin
      status_nxt = full ? ST_FULL : ST_INSERTED;
    end else begin
      status_nxt = empty ? ST_EMPTY : ST_POPPED;
    end
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt  = count_r - 1'b1;
      popped_nxt = entry[0];
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r    <= status_nxt;
      popped_r    <= popped_nxt;
      count_out_r <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_entry_count  = count_out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(2)) |-> (entry[0] <= entry[1]))
    else $error("front entries out of order");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_req_type == REQ_POP) && empty) |=>
      (out_status == ST_EMPTY) && (out_popped_value == '0) && $stable(count_r))
    else $error("pop on empty mishandled");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_req_type == REQ_INSERT) && full) |=>
      (out_status == ST_FULL) && $stable(count_r))
    else $error("insert on full mishandled");

endmodule
